// ===== rtl/c2sv_pkg.sv =====
package c2sv_pkg;

    // number format
    localparam int DATA_WIDTH = 32;

    // derived widths
    localparam int SQ_W    = 2 * DATA_WIDTH;       // sum of squares, unsigned
    localparam int RT_W    = DATA_WIDTH;           // square root result
    localparam int DOT_W   = 2 * DATA_WIDTH + 1;   // dot and cross sums, signed
    localparam int QW      = DATA_WIDTH + 3;       // quotient magnitude bits
    localparam int A_W     = QW + 1;               // signed in-plane radial term
    localparam int NUM_W   = 2 * DATA_WIDTH + 3;   // widest dividend, signed

    // unit latencies
    localparam int SQ_LAT  = RT_W;
    localparam int DIV_LAT = QW + 2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_AXIS   = 2'd1,
        ST_ORIGIN = 2'd2,
        ST_SAT    = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] pos_x;
        logic signed [DATA_WIDTH-1:0] pos_y;
        logic signed [DATA_WIDTH-1:0] pos_z;
        logic signed [DATA_WIDTH-1:0] vel_x;
        logic signed [DATA_WIDTH-1:0] vel_y;
        logic signed [DATA_WIDTH-1:0] vel_z;
    } sample_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] vel_radial;
        logic signed [DATA_WIDTH-1:0] vel_azimuth;
        logic signed [DATA_WIDTH-1:0] vel_polar;
        status_t                      status;
    } result_t;

    // divider result: sign, quotient overflow, truncated magnitude
    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [QW-1:0] mag;
    } div_res_t;

    typedef struct packed {
        logic                         sat;
        logic signed [DATA_WIDTH-1:0] val;
    } clamp_t;

    // clamp a divider result to the signed data range
    function automatic clamp_t clamp_res(div_res_t d);
        logic [QW-1:0] lim;
        clamp_t        c;
        lim = d.neg ? (QW'(1) << (DATA_WIDTH - 1))
                    : ((QW'(1) << (DATA_WIDTH - 1)) - QW'(1));
        c.sat = d.ovf || (d.mag > lim);
        if (c.sat)
        begin
            c.val = d.neg ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        else
        begin
            c.val = DATA_WIDTH'(d.neg ? (~d.mag + QW'(1)) : d.mag);
        end
        return c;
    endfunction

endpackage

// ===== rtl/c2sv_sqrt.sv =====
module c2sv_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [c2sv_pkg::SQ_W-1:0]   rad,
    output logic [c2sv_pkg::RT_W-1:0]   root
);

    localparam int SW = c2sv_pkg::SQ_W;
    localparam int RW = c2sv_pkg::RT_W;
    localparam int MW = RW + 3;

    logic [MW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [SW-1:0] rad_reg  [RW];

    // one result bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < RW; k++)
    begin : g_step
        logic [MW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [SW-1:0] rad_in;
        logic [MW-1:0] cur;
        logic [MW-1:0] trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        assign cur   = {rem_in[MW-3:0], rad_in[SW-1 -: 2]};
        assign trial = MW'({root_in, 2'b01});
        assign ge    = cur >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? cur - trial : cur;
                root_reg[k] <= {root_in[RW-2:0], ge};
                rad_reg[k]  <= {rad_in[SW-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

// ===== rtl/c2sv_div.sv =====
module c2sv_div (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [c2sv_pkg::NUM_W-1:0] num,
    input  logic        [c2sv_pkg::RT_W-1:0]  den,
    output c2sv_pkg::div_res_t                res
);

    localparam int NW = c2sv_pkg::NUM_W;
    localparam int QW = c2sv_pkg::QW;
    localparam int DW = c2sv_pkg::RT_W;

    // magnitude stage
    logic          neg_m_reg;
    logic [NW-1:0] mag_m_reg;
    logic [DW-1:0] den_m_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_m_reg <= num[NW-1];
            mag_m_reg <= num[NW-1] ? $unsigned(-num) : $unsigned(num);
            den_m_reg <= den;
        end
    end

    // overflow check, quotient must fit in QW bits
    logic          neg_o_reg;
    logic          ovf_o_reg;
    logic [DW-1:0] rem_o_reg;
    logic [QW-1:0] low_o_reg;
    logic [DW-1:0] den_o_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_o_reg <= neg_m_reg;
            ovf_o_reg <= mag_m_reg[NW-1:QW] >= den_m_reg;
            rem_o_reg <= mag_m_reg[NW-1:QW];
            low_o_reg <= mag_m_reg[QW-1:0];
            den_o_reg <= den_m_reg;
        end
    end

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [QW-1:0] low_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic          neg_reg [QW];
    logic          ovf_reg [QW];

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [DW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic [QW-1:0] low_in;
        logic [DW-1:0] den_in;
        logic          neg_in;
        logic          ovf_in;
        logic [DW:0]   cur;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_in = rem_o_reg;
            assign q_in   = '0;
            assign low_in = low_o_reg;
            assign den_in = den_o_reg;
            assign neg_in = neg_o_reg;
            assign ovf_in = ovf_o_reg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign low_in = low_reg[k-1];
            assign den_in = den_reg[k-1];
            assign neg_in = neg_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
        end

        assign cur  = {rem_in, low_in[QW-1]};
        assign diff = cur - {1'b0, den_in};
        assign ge   = cur >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DW-1:0] : cur[DW-1:0];
                q_reg[k]   <= {q_in[QW-2:0], ge};
                low_reg[k] <= {low_in[QW-2:0], 1'b0};
                den_reg[k] <= den_in;
                neg_reg[k] <= neg_in;
                ovf_reg[k] <= ovf_in;
            end
        end
    end

    assign res.neg = neg_reg[QW-1];
    assign res.ovf = ovf_reg[QW-1];
    assign res.mag = q_reg[QW-1];

endmodule

// ===== rtl/c2sv_skid.sv =====
module c2sv_skid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  c2sv_pkg::result_t   push_item,
    output logic                ready,
    output logic                result_valid,
    input  logic                result_stall,
    output c2sv_pkg::result_t   result
);

    c2sv_pkg::result_t ent_reg [2];
    logic              wr_reg;
    logic              rd_reg;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic              pop;

    assign ready        = cnt_reg != 2'd2;
    assign result_valid = cnt_reg != 2'd0;
    assign result       = ent_reg[rd_reg];
    assign pop          = result_valid && !result_stall;

    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/cartesian_to_spherical_velocity.sv =====
// channel   direction  handshake                     payload
// sample    in         sample_valid / sample_stall   c2sv_pkg::sample_t (position, velocity)
// result    out        result_valid / result_stall   c2sv_pkg::result_t (velocities, status)
//
// one item enters per cycle while the output buffer is not full
// the pipe is built from the bit-per-stage square roots (32 stages) and two chained
// bit-per-stage dividers (37 stages each) plus seven arithmetic stages and the output buffer
// rst_n clears the valid line and the output buffer; data registers are not reset
// the whole pipe freezes while the two-entry output buffer is full, so
// sample_stall comes from a register and never from result_stall directly
module cartesian_to_spherical_velocity (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  c2sv_pkg::sample_t   sample,
    output logic                result_valid,
    input  logic                result_stall,
    output c2sv_pkg::result_t   result
);

    localparam int W       = c2sv_pkg::DATA_WIDTH;
    localparam int P_W     = 2 * W;
    localparam int SQ_W    = c2sv_pkg::SQ_W;
    localparam int RT_W    = c2sv_pkg::RT_W;
    localparam int DOT_W   = c2sv_pkg::DOT_W;
    localparam int NUM_W   = c2sv_pkg::NUM_W;
    localparam int A_W     = c2sv_pkg::A_W;
    localparam int SQ_LAT  = c2sv_pkg::SQ_LAT;
    localparam int DIV_LAT = c2sv_pkg::DIV_LAT;
    localparam int ZA_W    = W + A_W;
    localparam int VZR_W   = 2 * W + 1;
    localparam int LAT     = 7 + SQ_LAT + 2 * DIV_LAT;

    // data that rides beside the square roots
    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic signed [DOT_W-1:0] dot_xy;
        logic signed [DOT_W-1:0] cr;
        logic signed [W-1:0]     z;
        logic signed [W-1:0]     vz;
        logic                    origin;
        logic                    axis;
    } side_a_t;

    // data that rides beside the first dividers
    typedef struct packed {
        logic signed [W-1:0] z;
        logic signed [W-1:0] vz;
        logic [RT_W-1:0]     r;
        logic [RT_W-1:0]     rho;
        logic                origin;
        logic                axis;
    } side_b_t;

    // finished terms that wait for the polar divider
    typedef struct packed {
        logic signed [W-1:0] vr;
        logic                vr_sat;
        logic signed [W-1:0] vphi;
        logic                vphi_sat;
        logic [RT_W-1:0]     r;
        logic                origin;
        logic                axis;
    } side_c_t;

    logic en;
    logic skid_ready;

    // global pipe enable, taken from the output buffer fill level
    assign en           = skid_ready;
    assign sample_stall = !en;

    // valid line, one bit per pipe stage
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], sample_valid};
        end
    end

    // stage 0: input register
    c2sv_pkg::sample_t s0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg <= sample;
        end
    end

    // stage 1: squares of the position and the velocity-position products
    logic signed [P_W-1:0] xx_reg;
    logic signed [P_W-1:0] yy_reg;
    logic signed [P_W-1:0] zz_reg;
    logic signed [P_W-1:0] vxx_reg;
    logic signed [P_W-1:0] vyy_reg;
    logic signed [P_W-1:0] vzz_reg;
    logic signed [P_W-1:0] vyx_reg;
    logic signed [P_W-1:0] vxy_reg;
    logic signed [W-1:0]   z1_reg;
    logic signed [W-1:0]   vz1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg  <= P_W'(s0_reg.pos_x) * P_W'(s0_reg.pos_x);
            yy_reg  <= P_W'(s0_reg.pos_y) * P_W'(s0_reg.pos_y);
            zz_reg  <= P_W'(s0_reg.pos_z) * P_W'(s0_reg.pos_z);
            vxx_reg <= P_W'(s0_reg.vel_x) * P_W'(s0_reg.pos_x);
            vyy_reg <= P_W'(s0_reg.vel_y) * P_W'(s0_reg.pos_y);
            vzz_reg <= P_W'(s0_reg.vel_z) * P_W'(s0_reg.pos_z);
            vyx_reg <= P_W'(s0_reg.vel_y) * P_W'(s0_reg.pos_x);
            vxy_reg <= P_W'(s0_reg.vel_x) * P_W'(s0_reg.pos_y);
            z1_reg  <= s0_reg.pos_z;
            vz1_reg <= s0_reg.vel_z;
        end
    end

    // stage 2: sums of squares, dot and cross sums, special-case flags
    logic [SQ_W-1:0] srho_reg;
    logic [SQ_W-1:0] sr_reg;
    side_a_t         sa2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srho_reg       <= $unsigned(xx_reg) + $unsigned(yy_reg);
            sr_reg         <= $unsigned(xx_reg) + $unsigned(yy_reg) + $unsigned(zz_reg);
            sa2_reg.dot    <= DOT_W'(vxx_reg) + DOT_W'(vyy_reg) + DOT_W'(vzz_reg);
            sa2_reg.dot_xy <= DOT_W'(vxx_reg) + DOT_W'(vyy_reg);
            sa2_reg.cr     <= DOT_W'(vyx_reg) - DOT_W'(vxy_reg);
            sa2_reg.z      <= z1_reg;
            sa2_reg.vz     <= vz1_reg;
            // squares are never negative, so zero squares mean zero coordinates
            sa2_reg.origin <= (xx_reg == '0) && (yy_reg == '0) && (zz_reg == '0);
            sa2_reg.axis   <= (xx_reg == '0) && (yy_reg == '0);
        end
    end

    // square roots of r^2 and rho^2
    logic [RT_W-1:0] r_root;
    logic [RT_W-1:0] rho_root;

    c2sv_sqrt u_sqrt_r (
        .clk  (clk),
        .en   (en),
        .rad  (sr_reg),
        .root (r_root)
    );

    c2sv_sqrt u_sqrt_rho (
        .clk  (clk),
        .en   (en),
        .rad  (srho_reg),
        .root (rho_root)
    );

    side_a_t sa_dly_reg [SQ_LAT];
    side_a_t sa_out;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_dly_reg[0] <= sa2_reg;
            for (int i = 1; i < SQ_LAT; i++)
            begin
                sa_dly_reg[i] <= sa_dly_reg[i-1];
            end
        end
    end

    assign sa_out = sa_dly_reg[SQ_LAT-1];

    // first divider bank: radial, azimuthal, and the in-plane term for polar
    c2sv_pkg::div_res_t vr_div;
    c2sv_pkg::div_res_t vphi_div;
    c2sv_pkg::div_res_t a_div;

    c2sv_div u_div_vr (
        .clk (clk),
        .en  (en),
        .num (NUM_W'(sa_out.dot)),
        .den (r_root),
        .res (vr_div)
    );

    c2sv_div u_div_vphi (
        .clk (clk),
        .en  (en),
        .num (NUM_W'(sa_out.cr)),
        .den (rho_root),
        .res (vphi_div)
    );

    c2sv_div u_div_a (
        .clk (clk),
        .en  (en),
        .num (NUM_W'(sa_out.dot_xy)),
        .den (rho_root),
        .res (a_div)
    );

    side_b_t sb_in;
    side_b_t sb_dly_reg [DIV_LAT];
    side_b_t sb_out;

    assign sb_in.z      = sa_out.z;
    assign sb_in.vz     = sa_out.vz;
    assign sb_in.r      = r_root;
    assign sb_in.rho    = rho_root;
    assign sb_in.origin = sa_out.origin;
    assign sb_in.axis   = sa_out.axis;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_dly_reg[0] <= sb_in;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sb_dly_reg[i] <= sb_dly_reg[i-1];
            end
        end
    end

    assign sb_out = sb_dly_reg[DIV_LAT-1];

    // stage 3: signed in-plane term, clamp radial and azimuthal results
    c2sv_pkg::clamp_t vr_c;
    c2sv_pkg::clamp_t vphi_c;

    assign vr_c   = c2sv_pkg::clamp_res(vr_div);
    assign vphi_c = c2sv_pkg::clamp_res(vphi_div);

    logic signed [A_W-1:0] a3_reg;
    logic signed [W-1:0]   z3_reg;
    logic signed [W-1:0]   vz3_reg;
    logic [RT_W-1:0]       rho3_reg;
    side_c_t               sc3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a3_reg           <= a_div.neg ? -$signed(A_W'(a_div.mag)) : $signed(A_W'(a_div.mag));
            z3_reg           <= sb_out.z;
            vz3_reg          <= sb_out.vz;
            rho3_reg         <= sb_out.rho;
            sc3_reg.vr       <= vr_c.val;
            sc3_reg.vr_sat   <= vr_c.sat;
            sc3_reg.vphi     <= vphi_c.val;
            sc3_reg.vphi_sat <= vphi_c.sat;
            sc3_reg.r        <= sb_out.r;
            sc3_reg.origin   <= sb_out.origin;
            sc3_reg.axis     <= sb_out.axis;
        end
    end

    // stage 4: z * a and vz * rho
    logic signed [ZA_W-1:0]  za4_reg;
    logic signed [VZR_W-1:0] vzr4_reg;
    side_c_t                 sc4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            za4_reg  <= ZA_W'(z3_reg) * ZA_W'(a3_reg);
            vzr4_reg <= VZR_W'(vz3_reg) * $signed(VZR_W'(rho3_reg));
            sc4_reg  <= sc3_reg;
        end
    end

    // stage 5: polar numerator
    logic signed [NUM_W-1:0] pn5_reg;
    side_c_t                 sc5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pn5_reg <= NUM_W'(za4_reg) - NUM_W'(vzr4_reg);
            sc5_reg <= sc4_reg;
        end
    end

    // second divider: polar velocity
    c2sv_pkg::div_res_t th_div;

    c2sv_div u_div_th (
        .clk (clk),
        .en  (en),
        .num (pn5_reg),
        .den (sc5_reg.r),
        .res (th_div)
    );

    side_c_t sc_dly_reg [DIV_LAT];
    side_c_t sc_out;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_dly_reg[0] <= sc5_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sc_dly_reg[i] <= sc_dly_reg[i-1];
            end
        end
    end

    assign sc_out = sc_dly_reg[DIV_LAT-1];

    // stage 6: polar clamp, status priority origin > axis > saturated
    c2sv_pkg::clamp_t  th_c;
    c2sv_pkg::result_t res6_next;
    c2sv_pkg::result_t res6_reg;

    assign th_c = c2sv_pkg::clamp_res(th_div);

    always_comb
    begin
        res6_next = '0;
        if (sc_out.origin)
        begin
            res6_next.status = c2sv_pkg::ST_ORIGIN;
        end
        else if (sc_out.axis)
        begin
            res6_next.vel_radial = sc_out.vr;
            res6_next.status     = c2sv_pkg::ST_AXIS;
        end
        else
        begin
            res6_next.vel_radial  = sc_out.vr;
            res6_next.vel_azimuth = sc_out.vphi;
            res6_next.vel_polar   = th_c.val;
            res6_next.status      = (sc_out.vr_sat || sc_out.vphi_sat || th_c.sat)
                                    ? c2sv_pkg::ST_SAT : c2sv_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res6_reg <= res6_next;
        end
    end

    // output buffer decouples result_stall from the pipe
    c2sv_skid u_skid (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (en && vld_reg[LAT-1]),
        .push_item    (res6_reg),
        .ready        (skid_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // origin results carry no velocity
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == c2sv_pkg::ST_ORIGIN) |->
        (result.vel_radial == '0 && result.vel_azimuth == '0 && result.vel_polar == '0))
        else $error("origin result with nonzero velocity");

    // on the z axis only the radial term survives
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == c2sv_pkg::ST_AXIS) |->
        (result.vel_azimuth == '0 && result.vel_polar == '0))
        else $error("axis result with nonzero azimuth or polar velocity");

    // a frozen pipe keeps the valid line in place
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid line moved while pipe frozen");

endmodule
